// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of this block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check with a fixed message.
`define TBCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tbcl assertion failed");

// Property check with a caller supplied message string.
`define TBCL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// File: rtl/core/tbcl_pkg.sv
`timescale 1ns / 1ps
package tbcl_pkg;

  // Division lanes. The first two take a shift of twice the fraction width.
  localparam int unsigned LANES = 7;
  localparam int unsigned LN_DX = 0;
  localparam int unsigned LN_DY = 1;
  localparam int unsigned LN_U  = 2;
  localparam int unsigned LN_P0 = 3;
  localparam int unsigned LN_P1 = 4;
  localparam int unsigned LN_T0 = 5;
  localparam int unsigned LN_T1 = 6;

  // Quotient bits produced by the divider below the saturation point.
  localparam int unsigned QBITS = 31;

  localparam int unsigned MARGIN_W = 17;

  // Numerators and shared denominator handed to the divider.
  typedef struct packed {
    logic [63:0]             den;
    logic [LANES-1:0]        neg;
    logic [LANES-1:0][63:0]  mag;
    logic                    degen;
  } num_t;

  // Quotient magnitudes with saturation and sign flags.
  typedef struct packed {
    logic [LANES-1:0]             neg;
    logic [LANES-1:0]             sat;
    logic [LANES-1:0][QBITS-1:0]  quo;
    logic                         degen;
  } quot_t;

  localparam logic signed [65:0] MAX64_W = {3'b000, {63{1'b1}}};
  localparam logic signed [65:0] MIN64_W = {3'b111, {63{1'b0}}};
  localparam logic signed [65:0] MAX32_W = {35'd0, {31{1'b1}}};
  localparam logic signed [65:0] MIN32_W = {{35{1'b1}}, {31{1'b0}}};

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
    logic signed [63:0] r;
    if (v > MAX64_W) begin
      r = {1'b0, {63{1'b1}}};
    end else if (v < MIN64_W) begin
      r = {1'b1, {63{1'b0}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > MAX32_W) begin
      r = {1'b0, {31{1'b1}}};
    end else if (v < MIN32_W) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/track_boundary_constraint_linearize_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Track boundary constraint linearization for one horizon stage per
// transaction. The block takes the vehicle position and the sampled
// center-line and outer-boundary points with their progress derivatives,
// and returns the saturated Q-format constraint Jacobian columns for x, y
// and progress together with the lateral bounds, or all zeros with the
// degenerate flag when the outer and center points coincide. A new
// transaction is accepted every clock cycle while the output side is not
// stalled. Each result passes through the difference, product, sum and
// numerator stages A to D, the pipelined restoring divider that forms
// all seven quotients against the shared squared norm, and the curvature
// correction and bound formation stages E to G. The user must write the
// safety margin register only while no transaction is in flight; the
// block itself does not enforce this.
module track_boundary_constraint_linearize_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbcl_pkg::MARGIN_W-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             centre_x_i,
  input  logic signed [31:0]             centre_y_i,
  input  logic signed [31:0]             outer_x_i,
  input  logic signed [31:0]             outer_y_i,
  input  logic signed [31:0]             centre_dx_i,
  input  logic signed [31:0]             centre_dy_i,
  input  logic signed [31:0]             outer_dx_i,
  input  logic signed [31:0]             outer_dy_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             jac_x_row0_o,
  output logic signed [31:0]             jac_x_row1_o,
  output logic signed [31:0]             jac_y_row0_o,
  output logic signed [31:0]             jac_y_row1_o,
  output logic signed [31:0]             jac_prog_row0_o,
  output logic signed [31:0]             jac_prog_row1_o,
  output logic signed [31:0]             lateral_lower_o,
  output logic signed [31:0]             lateral_upper_o,
  output logic                           degenerate_o
);
  import tbcl_pkg::*;

  // The safety margin register, in the same Q format as the data.
  logic [MARGIN_W-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  // The whole pipeline advances together. It only holds when a finished
  // result sits in the output register and the receiver stalls it, so
  // bubbles never block a new transaction.
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic   front_valid, div_valid;
  num_t   num;
  quot_t  quot;

  tbcl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .centre_x_i  (centre_x_i),
    .centre_y_i  (centre_y_i),
    .outer_x_i   (outer_x_i),
    .outer_y_i   (outer_y_i),
    .centre_dx_i (centre_dx_i),
    .centre_dy_i (centre_dy_i),
    .outer_dx_i  (outer_dx_i),
    .outer_dy_i  (outer_dy_i),
    .valid_o     (front_valid),
    .num_o       (num)
  );

  // All seven quotients share one denominator, the squared boundary
  // distance, and run side by side through the same divider stages.
  tbcl_qdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .num_i   (num),
    .valid_o (div_valid),
    .quot_o  (quot)
  );

  // The last stage of this unit is the output register.
  tbcl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (div_valid),
    .quot_i          (quot),
    .margin_i        (margin_q),
    .valid_o         (out_valid_o),
    .jac_x_row0_o    (jac_x_row0_o),
    .jac_x_row1_o    (jac_x_row1_o),
    .jac_y_row0_o    (jac_y_row0_o),
    .jac_y_row1_o    (jac_y_row1_o),
    .jac_prog_row0_o (jac_prog_row0_o),
    .jac_prog_row1_o (jac_prog_row1_o),
    .lateral_lower_o (lateral_lower_o),
    .lateral_upper_o (lateral_upper_o),
    .degenerate_o    (degenerate_o)
  );

  // Input backpressure only ever comes from a stalled output result.
  `TBCL_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i))

  // A degenerate result carries zero payload.
  `TBCL_ASSERT_MSG(a_degen_zero,
    (out_valid_o && degenerate_o) |-> (jac_x_row0_o == 0 && jac_prog_row0_o == 0 &&
    jac_prog_row1_o == 0 && lateral_lower_o == 0 && lateral_upper_o == 0),
    "degenerate result with nonzero payload")

  // Both diagonal entries of the rotation-scale matrix are the same quotient.
  `TBCL_ASSERT(a_diag_equal, out_valid_o |-> (jac_y_row1_o == jac_x_row0_o))

endmodule

// File: rtl/core/tbcl_front.sv
`timescale 1ns / 1ps
module tbcl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  centre_x_i,
  input  logic signed [31:0]  centre_y_i,
  input  logic signed [31:0]  outer_x_i,
  input  logic signed [31:0]  outer_y_i,
  input  logic signed [31:0]  centre_dx_i,
  input  logic signed [31:0]  centre_dy_i,
  input  logic signed [31:0]  outer_dx_i,
  input  logic signed [31:0]  outer_dy_i,
  output logic                valid_o,
  output tbcl_pkg::num_t      num_o
);
  import tbcl_pkg::*;

  // Stage A: saturated differences.
  logic va_q;
  logic signed [31:0] dx_q, dy_q, ex_q, ey_q, rx_q, ry_q, cdx_q, cdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= sat32(66'(outer_x_i) - 66'(centre_x_i));
      dy_q  <= sat32(66'(outer_y_i) - 66'(centre_y_i));
      ex_q  <= sat32(66'(outer_dx_i) - 66'(centre_dx_i));
      ey_q  <= sat32(66'(outer_dy_i) - 66'(centre_dy_i));
      rx_q  <= sat32(66'(pos_x_i) - 66'(centre_x_i));
      ry_q  <= sat32(66'(pos_y_i) - 66'(centre_y_i));
      cdx_q <= centre_dx_i;
      cdy_q <= centre_dy_i;
    end
  end

  // Stage B: one 32 by 32 product per multiplier.
  logic vb_q;
  logic signed [31:0] dxb_q, dyb_q;
  logic signed [63:0] p_dxdx_q, p_dydy_q, p_dxex_q, p_dyey_q;
  logic signed [63:0] p_dxrx_q, p_dyry_q, p_dxry_q, p_dyrx_q;
  logic signed [63:0] p_exrx_q, p_eyry_q, p_exry_q, p_eyrx_q;
  logic signed [63:0] p_dxcx_q, p_dycy_q, p_dxcy_q, p_dycx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxb_q    <= dx_q;
      dyb_q    <= dy_q;
      p_dxdx_q <= 64'(dx_q) * 64'(dx_q);
      p_dydy_q <= 64'(dy_q) * 64'(dy_q);
      p_dxex_q <= 64'(dx_q) * 64'(ex_q);
      p_dyey_q <= 64'(dy_q) * 64'(ey_q);
      p_dxrx_q <= 64'(dx_q) * 64'(rx_q);
      p_dyry_q <= 64'(dy_q) * 64'(ry_q);
      p_dxry_q <= 64'(dx_q) * 64'(ry_q);
      p_dyrx_q <= 64'(dy_q) * 64'(rx_q);
      p_exrx_q <= 64'(ex_q) * 64'(rx_q);
      p_eyry_q <= 64'(ey_q) * 64'(ry_q);
      p_exry_q <= 64'(ex_q) * 64'(ry_q);
      p_eyrx_q <= 64'(ey_q) * 64'(rx_q);
      p_dxcx_q <= 64'(dx_q) * 64'(cdx_q);
      p_dycy_q <= 64'(dy_q) * 64'(cdy_q);
      p_dxcy_q <= 64'(dx_q) * 64'(cdy_q);
      p_dycx_q <= 64'(dy_q) * 64'(cdx_q);
    end
  end

  // Stage C: norm, dot and cross sums.
  logic vc_q;
  logic signed [31:0] dxc_q, dyc_q;
  logic [63:0] n_q;
  logic signed [63:0] a_de_q, a_dr_q, c_dr_q, a_er_q, c_er_q, a_dc_q, c_dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxc_q  <= dxb_q;
      dyc_q  <= dyb_q;
      n_q    <= 64'(p_dxdx_q) + 64'(p_dydy_q);
      a_de_q <= sat64(66'(p_dxex_q) + 66'(p_dyey_q));
      a_dr_q <= sat64(66'(p_dxrx_q) + 66'(p_dyry_q));
      c_dr_q <= sat64(66'(p_dxry_q) - 66'(p_dyrx_q));
      a_er_q <= sat64(66'(p_exrx_q) + 66'(p_eyry_q));
      c_er_q <= sat64(66'(p_exry_q) - 66'(p_eyrx_q));
      a_dc_q <= sat64(66'(p_dxcx_q) + 66'(p_dycy_q));
      c_dc_q <= sat64(66'(p_dxcy_q) - 66'(p_dycx_q));
    end
  end

  // Stage D: final numerators split into sign and magnitude.
  logic signed [63:0] lane_val [LANES];
  num_t num_d, num_q;
  logic vd_q;

  always_comb begin
    lane_val[LN_DX] = 64'(dxc_q);
    lane_val[LN_DY] = 64'(dyc_q);
    lane_val[LN_U]  = a_de_q;
    lane_val[LN_P0] = a_dr_q;
    lane_val[LN_P1] = c_dr_q;
    lane_val[LN_T0] = sat64(66'(a_er_q) - 66'(a_dc_q));
    lane_val[LN_T1] = sat64(66'(c_er_q) - 66'(c_dc_q));
    num_d.den   = n_q;
    num_d.degen = (n_q == 64'd0);
    for (int l = 0; l < LANES; l++) begin
      num_d.neg[l] = lane_val[l][63];
      num_d.mag[l] = lane_val[l][63] ? 64'(-lane_val[l]) : 64'(lane_val[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
    end
  end

  assign valid_o = vd_q;
  assign num_o   = num_q;

endmodule

// File: rtl/core/tbcl_qdiv.sv
`timescale 1ns / 1ps
module tbcl_qdiv #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tbcl_pkg::num_t   num_i,
  output logic             valid_o,
  output tbcl_pkg::quot_t  quot_o
);
  import tbcl_pkg::*;

  // The first stage checks for overflow, each later stage retires one
  // quotient bit with one compare and subtract.
  localparam int NW  = 64 + 2 * FRAC_BITS + 32;
  localparam int RW  = 64 + QBITS;
  localparam int STG = QBITS + 1;

  logic                   v_q     [STG];
  logic [63:0]            den_q   [STG];
  logic [LANES-1:0]       neg_q   [STG];
  logic [LANES-1:0]       sat_q   [STG];
  logic                   degen_q [STG];
  logic [RW-1:0]          rem_q   [STG][LANES];
  logic [QBITS-1:0]       quo_q   [STG][LANES];

  logic [LANES-1:0]       sat_d0;
  logic [RW-1:0]          rem_d   [STG][LANES];
  logic [QBITS-1:0]       quo_d   [STG][LANES];

  always_comb begin
    logic [NW-1:0] num_w;
    logic [NW-1:0] lim_w;
    logic [RW-1:0] dsh;
    lim_w = NW'(num_i.den) << QBITS;
    for (int l = 0; l < LANES; l++) begin
      if (l == LN_DX || l == LN_DY) begin
        num_w = NW'(num_i.mag[l]) << (2 * FRAC_BITS);
      end else begin
        num_w = NW'(num_i.mag[l]) << FRAC_BITS;
      end
      sat_d0[l]     = (num_w >= lim_w);
      rem_d[0][l]   = sat_d0[l] ? '0 : num_w[RW-1:0];
      quo_d[0][l]   = '0;
    end
    for (int s = 1; s < STG; s++) begin
      for (int l = 0; l < LANES; l++) begin
        dsh = RW'(den_q[s-1]) << (QBITS - s);
        if (rem_q[s-1][l] >= dsh) begin
          rem_d[s][l] = rem_q[s-1][l] - dsh;
          quo_d[s][l] = quo_q[s-1][l] | (QBITS'(1) << (QBITS - s));
        end else begin
          rem_d[s][l] = rem_q[s-1][l];
          quo_d[s][l] = quo_q[s-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STG; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < STG; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]   <= num_i.den;
      neg_q[0]   <= num_i.neg;
      sat_q[0]   <= sat_d0;
      degen_q[0] <= num_i.degen;
      for (int s = 1; s < STG; s++) begin
        den_q[s]   <= den_q[s-1];
        neg_q[s]   <= neg_q[s-1];
        sat_q[s]   <= sat_q[s-1];
        degen_q[s] <= degen_q[s-1];
      end
      for (int s = 0; s < STG; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
      end
    end
  end

  always_comb begin
    quot_o.neg   = neg_q[STG-1];
    quot_o.sat   = sat_q[STG-1];
    quot_o.degen = degen_q[STG-1];
    for (int l = 0; l < LANES; l++) begin
      quot_o.quo[l] = quo_q[STG-1][l];
    end
  end

  assign valid_o = v_q[STG-1];

endmodule

// File: rtl/core/tbcl_back.sv
`timescale 1ns / 1ps
module tbcl_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  tbcl_pkg::quot_t                 quot_i,
  input  logic [tbcl_pkg::MARGIN_W-1:0]   margin_i,
  output logic                            valid_o,
  output logic signed [31:0]              jac_x_row0_o,
  output logic signed [31:0]              jac_x_row1_o,
  output logic signed [31:0]              jac_y_row0_o,
  output logic signed [31:0]              jac_y_row1_o,
  output logic signed [31:0]              jac_prog_row0_o,
  output logic signed [31:0]              jac_prog_row1_o,
  output logic signed [31:0]              lateral_lower_o,
  output logic signed [31:0]              lateral_upper_o,
  output logic                            degenerate_o
);
  import tbcl_pkg::*;

  localparam logic signed [31:0] MAX32 = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] MIN32 = {1'b1, {31{1'b0}}};
  localparam logic signed [33:0] ONE_Q = 34'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] qval(input logic neg, input logic sat,
                                              input logic [QBITS-1:0] q);
    logic signed [31:0] r;
    if (sat) begin
      r = neg ? MIN32 : MAX32;
    end else if (neg) begin
      r = 32'sd0 - $signed({1'b0, q});
    end else begin
      r = $signed({1'b0, q});
    end
    return r;
  endfunction

  // Stage E: signed quotients.
  logic ve_q, dge_q;
  logic signed [31:0] r0_q, r1_q, r2_q, u_q, p0_q, p1_q, t0_q, t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dge_q <= quot_i.degen;
      r0_q  <= qval(quot_i.neg[LN_DX], quot_i.sat[LN_DX], quot_i.quo[LN_DX]);
      r1_q  <= qval(!quot_i.neg[LN_DY], quot_i.sat[LN_DY], quot_i.quo[LN_DY]);
      r2_q  <= qval(quot_i.neg[LN_DY], quot_i.sat[LN_DY], quot_i.quo[LN_DY]);
      u_q   <= qval(quot_i.neg[LN_U], quot_i.sat[LN_U], quot_i.quo[LN_U]);
      p0_q  <= qval(quot_i.neg[LN_P0], quot_i.sat[LN_P0], quot_i.quo[LN_P0]);
      p1_q  <= qval(quot_i.neg[LN_P1], quot_i.sat[LN_P1], quot_i.quo[LN_P1]);
      t0_q  <= qval(quot_i.neg[LN_T0], quot_i.sat[LN_T0], quot_i.quo[LN_T0]);
      t1_q  <= qval(quot_i.neg[LN_T1], quot_i.sat[LN_T1], quot_i.quo[LN_T1]);
    end
  end

  // Stage F: curvature products u * p.
  logic vf_q, dgf_q;
  logic signed [31:0] r0f_q, r1f_q, r2f_q, p0f_q, t0f_q, t1f_q;
  logic signed [63:0] up0_q, up1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dgf_q <= dge_q;
      r0f_q <= r0_q;
      r1f_q <= r1_q;
      r2f_q <= r2_q;
      p0f_q <= p0_q;
      t0f_q <= t0_q;
      t1f_q <= t1_q;
      up0_q <= 64'(u_q) * 64'(p0_q);
      up1_q <= 64'(u_q) * 64'(p1_q);
    end
  end

  // Stage G: twice the product truncated toward zero, final sums, bounds.
  function automatic logic signed [63:0] twice_trunc(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] sh;
    logic signed [63:0] r;
    m  = p[63] ? 64'(-p) : 64'(p);
    sh = m >> (FRAC_BITS - 1);
    r  = p[63] ? -$signed(sh) : $signed(sh);
    return r;
  endfunction

  logic vg_q;
  logic signed [33:0] lim;
  logic signed [31:0] pr0_d, pr1_d, lo_d, hi_d;

  always_comb begin
    lim   = ONE_Q - $signed({17'd0, margin_i});
    pr0_d = sat32(66'(t0f_q) - 66'(twice_trunc(up0_q)));
    pr1_d = sat32(66'(t1f_q) - 66'(twice_trunc(up1_q)));
    lo_d  = sat32(-66'(lim) - 66'(p0f_q));
    hi_d  = sat32(66'(lim) - 66'(p0f_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en_i) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      degenerate_o <= dgf_q;
      if (dgf_q) begin
        jac_x_row0_o    <= '0;
        jac_x_row1_o    <= '0;
        jac_y_row0_o    <= '0;
        jac_y_row1_o    <= '0;
        jac_prog_row0_o <= '0;
        jac_prog_row1_o <= '0;
        lateral_lower_o <= '0;
        lateral_upper_o <= '0;
      end else begin
        jac_x_row0_o    <= r0f_q;
        jac_x_row1_o    <= r1f_q;
        jac_y_row0_o    <= r2f_q;
        jac_y_row1_o    <= r0f_q;
        jac_prog_row0_o <= pr0_d;
        jac_prog_row1_o <= pr1_d;
        lateral_lower_o <= lo_d;
        lateral_upper_o <= hi_d;
      end
    end
  end

  assign valid_o = vg_q;

endmodule
